FILE: rtl/lpa_pkg.sv
// Shared types and constants for the label pool allocator.
// Used by the engine, output register, top level and checker; depends on nothing.
package lpa_pkg;

  localparam int LABEL_SLOTS_DEF = 1024;
  localparam int MAX_MEMBERS_DEF = 65535;

  localparam int REQ_W     = 3;
  localparam int LABEL_W   = 10;
  localparam int SIZE_W    = 17;
  localparam int COUNT_W   = 11;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 3'd0,
    REQ_COUNT = 3'd1,
    REQ_ALLOC = 3'd2,
    REQ_FREE  = 3'd3,
    REQ_QUERY = 3'd4
  } req_t;

  typedef struct packed {
    logic [LABEL_W-1:0]        top_label;
    logic [COUNT_W-1:0]        labels_in_use;
    logic signed [SIZE_W-1:0]  label_size;
    logic [LABEL_W-1:0]        result_label;
    logic                      pool_full;
  } res_t;

endpackage

FILE: rtl/lpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while no read is issued. No dependencies.
module lpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lpa_out_stage.sv
// Output register of the label pool allocator: holds one result for the master side.
// Depends on lpa_pkg for the result struct and port widths.
module lpa_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  output logic                           res_ready,
  input  lpa_pkg::res_t                  res,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lpa_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [0:0]                     m_tuser
);

  lpa_pkg::res_t held;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

  assign m_tdata = {held.top_label, held.labels_in_use, held.label_size, held.result_label};
  assign m_tuser = held.pool_full;

endmodule

FILE: rtl/lpa_engine.sv
// Request sequencer of the label pool allocator: read-modify-write on the size
// table RAM, table scans, clear sweep and the two counters. Depends on lpa_pkg.
module lpa_engine #(
  parameter int LABEL_SLOTS = lpa_pkg::LABEL_SLOTS_DEF,
  parameter int MAX_MEMBERS = lpa_pkg::MAX_MEMBERS_DEF,
  localparam int AW = $clog2(LABEL_SLOTS),
  localparam int SW = $clog2(MAX_MEMBERS + 1) + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpa_pkg::REQ_W-1:0]     in_req,
  input  logic [lpa_pkg::LABEL_W-1:0]   in_label,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lpa_pkg::res_t                 res,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic signed [SW-1:0]          wr_data,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  logic signed [SW-1:0]          rd_data
);

  localparam int CW = $clog2(LABEL_SLOTS + 1);
  localparam logic [AW:0]           SLOTS_N   = (AW+1)'(LABEL_SLOTS);
  localparam logic [AW-1:0]         LAST_IDX  = AW'(LABEL_SLOTS - 1);
  localparam logic [CW-1:0]         USED_MAX  = CW'(LABEL_SLOTS);
  localparam logic signed [SW-1:0]  SIZE_MAX  = SW'(MAX_MEMBERS);
  localparam logic signed [SW-1:0]  RESERVED  = '1;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_EXE, ST_SCAN, ST_DESC, ST_RESP
  } state_t;

  state_t                          state;
  logic [lpa_pkg::REQ_W-1:0]       req;
  logic [lpa_pkg::LABEL_W-1:0]     lab;
  logic [CW-1:0]                   used;
  logic [AW-1:0]                   highest;
  logic [AW-1:0]                   clr_idx;
  logic                            clr_resp;
  logic [AW:0]                     scan_issue;
  logic [AW-1:0]                   dn_issue;
  logic                            dn_last;
  logic                            pend_vld;
  logic [AW-1:0]                   pend_idx;
  logic [lpa_pkg::LABEL_W-1:0]     rlab;
  logic signed [lpa_pkg::SIZE_W-1:0] rsize;
  logic                            rfull;

  logic [AW-1:0]                   addr;
  logic                            in_range;
  logic                            slot_used;
  logic signed [SW-1:0]            cnt_next;
  logic                            found;
  logic                            desc_stop;

  assign addr      = AW'(lab);
  assign in_range  = 32'(lab) < 32'(LABEL_SLOTS);
  assign slot_used = rd_data != '0;
  assign found     = pend_vld && !slot_used;
  assign desc_stop = pend_vld && (slot_used || pend_idx == '0);

  // Empty and reserved slots restart at one member; full slots saturate.
  always_comb begin
    if (rd_data == '0 || rd_data[SW-1]) begin
      cnt_next = SW'(1);
    end else if (rd_data < SIZE_MAX) begin
      cnt_next = rd_data + SW'(1);
    end else begin
      cnt_next = SIZE_MAX;
    end
  end

  assign in_ready  = state == ST_IDLE;
  assign res_valid = state == ST_RESP;

  always_comb begin
    res.top_label     = lpa_pkg::LABEL_W'(highest);
    res.labels_in_use = lpa_pkg::COUNT_W'(used);
    res.label_size    = rsize;
    res.result_label  = rlab;
    res.pool_full     = rfull;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = AW'(in_label);
    case (state)
      ST_IDLE: begin
        rd_en = in_valid;
      end
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
      end
      ST_EXE: begin
        if (req == lpa_pkg::REQ_COUNT && in_range) begin
          wr_en   = 1'b1;
          wr_data = cnt_next;
        end else if (req == lpa_pkg::REQ_FREE && in_range && slot_used) begin
          wr_en = 1'b1;
        end
      end
      ST_SCAN: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx;
          wr_data = RESERVED;
        end else if (scan_issue < SLOTS_N) begin
          rd_en   = 1'b1;
          rd_addr = AW'(scan_issue);
        end
      end
      ST_DESC: begin
        if (!desc_stop && !dn_last) begin
          rd_en   = 1'b1;
          rd_addr = dn_issue;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_idx  <= '0;
      clr_resp <= 1'b0;
      used     <= '0;
      highest  <= '0;
      pend_vld <= 1'b0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            clr_idx <= '0;
            used    <= '0;
            highest <= '0;
            rlab    <= lab;
            rsize   <= '0;
            rfull   <= 1'b0;
            state   <= clr_resp ? ST_RESP : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_req;
            lab   <= in_label;
            state <= ST_EXE;
          end
        end
        ST_EXE: begin
          rlab  <= lab;
          rsize <= '0;
          rfull <= 1'b0;
          state <= ST_RESP;
          case (req)
            lpa_pkg::REQ_CLEAR: begin
              clr_resp <= 1'b1;
              clr_idx  <= '0;
              state    <= ST_CLR;
            end
            lpa_pkg::REQ_COUNT: begin
              if (in_range) begin
                rsize <= lpa_pkg::SIZE_W'(cnt_next);
                if (rd_data == '0 && used < USED_MAX) begin
                  used <= used + 1'b1;
                end
                if (!(slot_used && !rd_data[SW-1]) && addr > highest) begin
                  highest <= addr;
                end
              end
            end
            lpa_pkg::REQ_ALLOC: begin
              scan_issue <= '0;
              pend_vld   <= 1'b0;
              state      <= ST_SCAN;
            end
            lpa_pkg::REQ_FREE: begin
              if (in_range && slot_used) begin
                if (used != '0) begin
                  used <= used - 1'b1;
                end
                // Walk the top label down past empty slots below the freed one.
                if (addr == highest && addr != '0) begin
                  dn_issue <= addr - 1'b1;
                  dn_last  <= 1'b0;
                  pend_vld <= 1'b0;
                  state    <= ST_DESC;
                end
              end
            end
            lpa_pkg::REQ_QUERY: begin
              if (in_range) begin
                rsize <= lpa_pkg::SIZE_W'(rd_data);
              end
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (found) begin
            if (used < USED_MAX) begin
              used <= used + 1'b1;
            end
            if (pend_idx > highest) begin
              highest <= pend_idx;
            end
            rlab     <= lpa_pkg::LABEL_W'(pend_idx);
            rsize    <= lpa_pkg::SIZE_W'(RESERVED);
            rfull    <= 1'b0;
            pend_vld <= 1'b0;
            state    <= ST_RESP;
          end else if (!pend_vld && scan_issue == SLOTS_N) begin
            rlab  <= '0;
            rsize <= '0;
            rfull <= 1'b1;
            state <= ST_RESP;
          end else if (scan_issue < SLOTS_N) begin
            pend_vld   <= 1'b1;
            pend_idx   <= AW'(scan_issue);
            scan_issue <= scan_issue + 1'b1;
          end else begin
            pend_vld <= 1'b0;
          end
        end
        ST_DESC: begin
          if (desc_stop) begin
            highest  <= pend_idx;
            pend_vld <= 1'b0;
            state    <= ST_RESP;
          end else if (!dn_last) begin
            pend_vld <= 1'b1;
            pend_idx <= dn_issue;
            if (dn_issue == '0) begin
              dn_last <= 1'b1;
            end else begin
              dn_issue <= dn_issue - 1'b1;
            end
          end else begin
            pend_vld <= 1'b0;
          end
        end
        ST_RESP: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/label_pool_allocator.sv
// Top level of the label pool allocator: request sequencer, size table RAM and
// output register. Depends on lpa_pkg, lpa_engine, lpa_ram and lpa_out_stage.
//
//   channel   dir  transfer content
//   s_*       in   tuser[2:0] req_type; tdata[9:0] label
//   m_*       out  tdata: result_label, label_size, labels_in_use, top_label;
//                  tuser[0] pool_full
//
// Count, query, free and undefined requests are accepted with the table read,
// executed with write-back, then handed to the output register.
// Allocate adds a scan of one table entry per cycle from label 0; freeing the
// top label walks down one entry per cycle. Clear sweeps the table, writing
// zero to every entry; after reset the same sweep runs with s_tready low.
// A new request is accepted while a result waits on m_tready.
module label_pool_allocator #(
  parameter int LABEL_SLOTS = lpa_pkg::LABEL_SLOTS_DEF,
  parameter int MAX_MEMBERS = lpa_pkg::MAX_MEMBERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lpa_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] label
  input  logic [lpa_pkg::REQ_W-1:0]      s_tuser,   // [2:0] req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lpa_pkg::M_TDATA_W-1:0]  m_tdata,   // [9:0] result_label,
                                                    // [26:10] label_size,
                                                    // [37:27] labels_in_use,
                                                    // [47:38] top_label
  output logic [0:0]                     m_tuser    // [0] pool_full
);

  localparam int AW = $clog2(LABEL_SLOTS);
  localparam int SW = $clog2(MAX_MEMBERS + 1) + 1;

  logic                  res_valid;
  logic                  res_ready;
  lpa_pkg::res_t         res;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic signed [SW-1:0]  wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic signed [SW-1:0]  rd_data;

  lpa_engine #(
    .LABEL_SLOTS (LABEL_SLOTS),
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_label  (s_tdata[lpa_pkg::LABEL_W-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  lpa_ram #(
    .WIDTH (SW),
    .DEPTH (LABEL_SLOTS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpa_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: rtl/lpa_checker.sv
// Port-level checks for the label pool allocator, bound to the top level.
// Depends on lpa_pkg and label_pool_allocator.
module lpa_checker #(
  parameter int LABEL_SLOTS = lpa_pkg::LABEL_SLOTS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [lpa_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic [lpa_pkg::REQ_W-1:0]      s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lpa_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [0:0]                     m_tuser
);

  // One request in flight: the sink closes right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[26:10] == 17'd0 && m_tdata[9:0] == 10'd0)
    else $error("full result carries a label or size");

  a_reserved_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[26] |-> m_tdata[26:10] == 17'h1FFFF)
    else $error("negative size other than reserved");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[37:27]) <= 32'(LABEL_SLOTS))
    else $error("labels in use exceeds slot count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind label_pool_allocator lpa_checker #(.LABEL_SLOTS(LABEL_SLOTS)) u_lpa_checker (.*);

FILE: test/label_pool_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for label_pool_allocator: drives size-table requests on the
// stream input and checks every result against a cycle-free table predictor.
// Depends on lpa_pkg and the label_pool_allocator RTL only.
module label_pool_allocator_tb;

  localparam int LABEL_SLOTS    = lpa_pkg::LABEL_SLOTS_DEF;
  localparam int MAX_MEMBERS    = lpa_pkg::MAX_MEMBERS_DEF;
  localparam int WATCHDOG_LIMIT = 8 * LABEL_SLOTS;
  localparam int BURST_ITEMS    = 100;
  localparam int RANDOM_ITEMS   = 500;
  localparam int PRINT_LIMIT    = 40;

  // Request codes the block treats as no-ops.
  localparam logic [lpa_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [lpa_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [lpa_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;

  // Mirror of the size table; predicts one reply per request.
  class label_pool_tracker;
    logic signed [lpa_pkg::SIZE_W-1:0] sizes [LABEL_SLOTS];
    logic [lpa_pkg::LABEL_W-1:0]       top;
    logic [lpa_pkg::COUNT_W-1:0]       in_use;
    lpa_pkg::res_t                     expected_replies [$];
    int                                mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      foreach (sizes[i]) sizes[i] = '0;
      top    = '0;
      in_use = '0;
    endfunction

    function lpa_pkg::res_t apply_request(logic [lpa_pkg::REQ_W-1:0] kind,
                                          logic [lpa_pkg::LABEL_W-1:0] lab);
      lpa_pkg::res_t                     r;
      logic signed [lpa_pkg::SIZE_W-1:0] cur;
      int                                slot;
      r.result_label  = lab;
      r.label_size    = '0;
      r.pool_full     = 1'b0;
      case (kind)
        lpa_pkg::REQ_CLEAR: wipe();
        lpa_pkg::REQ_COUNT: begin
          cur = sizes[lab];
          if (cur == 0) begin
            sizes[lab] = 1;
            if (in_use < LABEL_SLOTS) in_use++;
            if (lab > top) top = lab;
          end else if (cur < 0) begin
            // reserved slot becomes a real label, already counted as used
            sizes[lab] = 1;
            if (lab > top) top = lab;
          end else if (cur < MAX_MEMBERS) begin
            sizes[lab] = cur + lpa_pkg::SIZE_W'(1);
          end else begin
            sizes[lab] = lpa_pkg::SIZE_W'(MAX_MEMBERS);
          end
          r.label_size = sizes[lab];
        end
        lpa_pkg::REQ_ALLOC: begin
          slot = 0;
          while (slot < LABEL_SLOTS && sizes[slot] != 0) slot++;
          if (slot < LABEL_SLOTS) begin
            sizes[slot] = '1;
            if (in_use < LABEL_SLOTS) in_use++;
            if (slot > top) top = lpa_pkg::LABEL_W'(slot);
            r.result_label = lpa_pkg::LABEL_W'(slot);
            r.label_size   = '1;
          end else begin
            r.result_label = '0;
            r.pool_full    = 1'b1;
          end
        end
        lpa_pkg::REQ_FREE: begin
          if (sizes[lab] != 0) begin
            sizes[lab] = '0;
            // walk the top label down past empty slots
            if (lab == top) begin
              while (top > 0 && sizes[top] == 0) top--;
            end
            if (in_use > 0) in_use--;
          end
        end
        lpa_pkg::REQ_QUERY: r.label_size = sizes[lab];
        default: ;
      endcase
      r.labels_in_use = in_use;
      r.top_label     = top;
      return r;
    endfunction

    function void note_request(logic [lpa_pkg::REQ_W-1:0] kind,
                               logic [lpa_pkg::LABEL_W-1:0] lab);
      expected_replies.push_back(apply_request(kind, lab));
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
      if (mismatches < PRINT_LIMIT)
        $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got_v, exp_v);
      mismatches++;
    endtask

    task check_result(lpa_pkg::res_t got);
      lpa_pkg::res_t exp;
      if (expected_replies.size() == 0) begin
        report("unexpected transfer, result_label", 32'(got.result_label), 32'd0);
      end else begin
        exp = expected_replies.pop_front();
        if (got.result_label !== exp.result_label)
          report("result_label", 32'(got.result_label), 32'(exp.result_label));
        if (got.label_size !== exp.label_size)
          report("label_size", 32'(got.label_size), 32'(exp.label_size));
        if (got.labels_in_use !== exp.labels_in_use)
          report("labels_in_use", 32'(got.labels_in_use), 32'(exp.labels_in_use));
        if (got.top_label !== exp.top_label)
          report("top_label", 32'(got.top_label), 32'(exp.top_label));
        if (got.pool_full !== exp.pool_full)
          report("pool_full", 32'(got.pool_full), 32'(exp.pool_full));
      end
    endtask

    task flush_leftovers();
      lpa_pkg::res_t exp;
      while (expected_replies.size() != 0) begin
        exp = expected_replies.pop_front();
        report("missing transfer, result_label", 32'd0, 32'(exp.result_label));
      end
    endtask
  endclass

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [lpa_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
  logic [lpa_pkg::REQ_W-1:0]       s_tuser  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [lpa_pkg::M_TDATA_W-1:0]   m_tdata;
  logic [0:0]                      m_tuser;

  label_pool_tracker tracker = new();
  int idle_pct     = 16;
  int stall_cycles = 0;

  label_pool_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Note accepted requests, check accepted results, drive the result-side stall.
  always @(posedge clk) begin
    lpa_pkg::res_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.result_label  = m_tdata[9:0];
        got.label_size    = m_tdata[26:10];
        got.labels_in_use = m_tdata[37:27];
        got.top_label     = m_tdata[47:38];
        got.pool_full     = m_tuser[0];
        tracker.check_result(got);
      end
      if (s_tvalid && s_tready)
        tracker.note_request(s_tuser, s_tdata[lpa_pkg::LABEL_W-1:0]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("label_pool_allocator_tb NOT OK");
      $finish;
    end
  end

  // Hold valid off for a random gap, then present one request until it transfers.
  task automatic send_request(input logic [lpa_pkg::REQ_W-1:0] kind,
                              input logic [lpa_pkg::LABEL_W-1:0] lab);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(lpa_pkg::S_TDATA_W-lpa_pkg::LABEL_W){1'b0}}, lab};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int                          order [LABEL_SLOTS];
    int                          j;
    int                          tmp;
    int                          pick;
    logic [lpa_pkg::LABEL_W-1:0] hole;
    logic [lpa_pkg::LABEL_W-1:0] lab;
    logic [lpa_pkg::REQ_W-1:0]   kind;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, reserved slots, top walk-down, undefined requests, clear.
    send_request(lpa_pkg::REQ_QUERY, 10'd0);
    send_request(lpa_pkg::REQ_QUERY, 10'h3FF);
    send_request(lpa_pkg::REQ_COUNT, 10'h3FF);
    send_request(lpa_pkg::REQ_COUNT, 10'd0);
    send_request(lpa_pkg::REQ_COUNT, 10'd0);
    send_request(lpa_pkg::REQ_FREE, 10'd5);
    send_request(lpa_pkg::REQ_ALLOC, 10'h2AA);
    send_request(lpa_pkg::REQ_ALLOC, 10'h155);
    send_request(lpa_pkg::REQ_COUNT, 10'd2);
    send_request(lpa_pkg::REQ_QUERY, 10'd1);
    send_request(lpa_pkg::REQ_FREE, 10'h3FF);
    send_request(lpa_pkg::REQ_FREE, 10'd2);
    send_request(lpa_pkg::REQ_FREE, 10'd1);
    send_request(REQ_SPARE_A, 10'h2AA);
    send_request(REQ_SPARE_B, 10'h155);
    send_request(REQ_SPARE_C, 10'h3FF);
    send_request(lpa_pkg::REQ_CLEAR, 10'h3FF);
    send_request(lpa_pkg::REQ_QUERY, 10'd0);
    send_request(lpa_pkg::REQ_ALLOC, 10'd0);
    send_request(lpa_pkg::REQ_FREE, 10'd0);
    send_request(lpa_pkg::REQ_COUNT, 10'd512);
    send_request(lpa_pkg::REQ_QUERY, 10'd512);
    wait_for_results();

    // Burst of counts on one label, no idling on either side.
    idle_pct = 0;
    for (int n = 0; n < BURST_ITEMS; n++) send_request(lpa_pkg::REQ_COUNT, 10'h155);
    send_request(lpa_pkg::REQ_QUERY, 10'h155);
    idle_pct = 16;

    // Fill every slot in shuffled order, then exercise a full pool.
    send_request(lpa_pkg::REQ_CLEAR, 10'd0);
    foreach (order[i]) order[i] = i;
    for (int i = LABEL_SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_request(lpa_pkg::REQ_COUNT, lpa_pkg::LABEL_W'(order[i]));
    hole = lpa_pkg::LABEL_W'($urandom_range(LABEL_SLOTS - 1));
    send_request(lpa_pkg::REQ_ALLOC, 10'd0);
    send_request(lpa_pkg::REQ_FREE, hole);
    send_request(lpa_pkg::REQ_ALLOC, 10'd0);
    send_request(lpa_pkg::REQ_ALLOC, 10'd0);
    send_request(lpa_pkg::REQ_QUERY, hole);
    send_request(lpa_pkg::REQ_COUNT, hole);
    send_request(lpa_pkg::REQ_FREE, 10'h3FF);
    send_request(lpa_pkg::REQ_QUERY, 10'h3FF);
    send_request(lpa_pkg::REQ_CLEAR, 10'd0);

    // Random traffic, mostly on a small working set of labels.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_results();
      pick = $urandom_range(99);
      lab  = lpa_pkg::LABEL_W'(($urandom_range(99) < 85) ? $urandom_range(63)
                                                         : $urandom_range(LABEL_SLOTS - 1));
      if (pick < 45)      kind = lpa_pkg::REQ_COUNT;
      else if (pick < 63) kind = lpa_pkg::REQ_QUERY;
      else if (pick < 81) kind = lpa_pkg::REQ_FREE;
      else if (pick < 94) kind = lpa_pkg::REQ_ALLOC;
      else if (pick < 97)
        kind = lpa_pkg::REQ_W'($urandom_range(32'(REQ_SPARE_C), 32'(REQ_SPARE_A)));
      else                kind = lpa_pkg::REQ_CLEAR;
      send_request(kind, lab);
    end

    wait_for_results();
    repeat (2 * LABEL_SLOTS + 16) @(posedge clk);
    tracker.flush_leftovers();
    if (tracker.mismatches == 0) begin
      $display("label_pool_allocator_tb OK");
    end else begin
      $display("label_pool_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lpa_pkg.sv
rtl/lpa_ram.sv
rtl/lpa_out_stage.sv
rtl/lpa_engine.sv
rtl/label_pool_allocator.sv
rtl/lpa_checker.sv
test/label_pool_allocator_tb.sv
